@@ hdl/arwt_pkg.sv @@
`default_nettype none
package arwt_pkg;

  // Table geometry
  localparam int SLOTS     = 16;
  localparam int MAX_OUT   = 16;
  localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int HITS_W    = $clog2(MAX_OUT + 1);
  localparam int ADDR_W    = 32;
  localparam int LEN_W     = 16;
  localparam int END_W     = ADDR_W + 1;
  localparam int IDX_OUT_W = 4;

  // Stream and register port widths
  localparam int S_DATA_W   = 88;
  localparam int S_USER_W   = 2;
  localparam int M_DATA_W   = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register index (byte address / 4)
  localparam logic [CFG_ADDR_W-3:0] REG_BRK_ADDR = '0;

  typedef enum logic [1:0] {
    MODE_CHECK  = 2'd0,
    MODE_ARM    = 2'd1,
    MODE_DISARM = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  typedef struct packed {
    logic [END_W-1:0]  high;
    logic [ADDR_W-1:0] low;
  } slot_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    slot_t            data;
  } wr_req_t;

  typedef struct packed {
    logic                 brk;
    logic                 status;
    logic                 last;
    logic                 hit;
    logic [IDX_OUT_W-1:0] slot_index;
  } res_t;

endpackage
`default_nettype wire

@@ hdl/arwt_slot_ram.sv @@
`default_nettype none
module arwt_slot_ram (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  arwt_pkg::rd_req_t rd_i,
  input  arwt_pkg::wr_req_t wr_i,
  input  logic             clear_i,
  output arwt_pkg::slot_t  rd_data_o
);
  import arwt_pkg::*;

  slot_t            mem_q [SLOTS];
  slot_t            rd_q;
  logic [SLOTS-1:0] valid_q;
  logic             rd_valid_q;

  // Range storage, registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_q <= mem_q[rd_i.addr];
    end
  end

  // Track written entries; an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (clear_i) begin
        valid_q <= '0;
      end else if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.en) begin
        rd_valid_q <= valid_q[rd_i.addr];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_q : '0;

endmodule
`default_nettype wire

@@ hdl/arwt_out_reg.sv @@
`default_nettype none
module arwt_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  arwt_pkg::res_t data_i,
  output logic           can_push_o,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output arwt_pkg::res_t data_o
);
  import arwt_pkg::*;

  logic vld_q, vld_d;
  res_t data_q;

  assign can_push_o = !vld_q || m_ready_i;

  // Hold one result until the receiver takes it
  always_comb begin
    vld_d = vld_q;
    if (push_i) begin
      vld_d = 1'b1;
    end else if (m_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= data_i;
    end
  end

  assign m_valid_o = vld_q;
  assign data_o    = data_q;

endmodule
`default_nettype wire

@@ hdl/address_range_watch_table.sv @@
// Address range watch table: up to 16 watched byte ranges kept in a slot RAM.
// Input stream (s_axis_*): tuser carries the operation (check access, arm,
// disarm, clear all); tdata carries base address, length, disarm limit and
// the remove flag. Output stream (m_axis_*): tdata carries slot index, hit,
// status and the break-disabled flag; tlast marks the final result of an item.
// A check gives one result per overlapping active slot, highest slot first,
// or one no-hit result; every other operation gives exactly one result.
// One item is taken at a time. It is accepted, then the slots are read
// from the registered RAM one at a time (check and disarm: high-water mark
// slots; arm: slots up to the one taken, at most 16), and then the last
// result is drained. A check or a disarm with a high-water mark of zero and
// a clear read no slot and go straight to draining. The single RAM read port
// sets the scan rate.
// A stalled receiver holds the output register; a check that finds a further
// hit then waits on the RAM read until the register frees up. After the last
// result is loaded the block takes the next item even if it is not yet taken.
// Reset empties the table, the high-water mark and the break-disabled flag
// and sets the break-disable address register to zero. APB register 0 at
// byte address 0 is the break-disable address.
`default_nettype none
module address_range_watch_table (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [31:0] base_address, [47:32] length, [79:48] limit_address,
  // [80] remove_request, [87:81] zero
  input  logic [arwt_pkg::S_DATA_W-1:0]          s_axis_tdata,
  // [1:0] mode
  input  logic [arwt_pkg::S_USER_W-1:0]          s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [3:0] slot_index, [4] hit, [5] status, [6] break_disabled, [7] zero
  output logic [arwt_pkg::M_DATA_W-1:0]          m_axis_tdata,
  output logic                                  m_axis_tlast,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [arwt_pkg::CFG_ADDR_W-1:0]        paddr,
  input  logic [arwt_pkg::CFG_DATA_W-1:0]        pwdata,
  output logic [arwt_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                  pready
);
  import arwt_pkg::*;

  // Control and item registers
  state_e             state_q, state_d;
  mode_e              mode_q, mode_d;
  logic [ADDR_W-1:0]  base_q, base_d;
  logic [END_W-1:0]   end_q, end_d;
  logic [ADDR_W-1:0]  limit_q, limit_d;
  logic               remove_q, remove_d;
  logic [ADDR_W-1:0]  brk_addr_q;
  logic               brk_q, brk_d;
  logic [CNT_W-1:0]   hw_q, hw_d;
  logic [SLOTS-1:0]   active_q, active_d;
  logic [IDX_W-1:0]   ptr_q, ptr_d;
  logic [CNT_W-1:0]   rem_q, rem_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]   cmp_idx_q, cmp_idx_d;
  logic               cmp_last_q, cmp_last_d;
  logic               pend_vld_q, pend_vld_d;
  logic [IDX_W-1:0]   pend_idx_q, pend_idx_d;
  logic [HITS_W-1:0]  hits_q, hits_d;
  logic               full_q, full_d;
  logic [CNT_W-1:0]   top_q, top_d;

  // RAM and output register connections
  rd_req_t rd_req;
  wr_req_t wr_req;
  logic    ram_clear;
  slot_t   rd_data;
  logic    push;
  res_t    res;
  logic    can_push;
  res_t    out_res;

  // Compare of the entry read in the previous cycle
  logic             cmp_active;
  logic             check_hit;
  logic             arm_match;
  logic             arm_free;
  logic             dis_in;
  logic             stall;
  logic             stop;
  logic             proc;
  logic             done_scan;
  logic             issue;
  logic [CNT_W-1:0] cmp_idx_w;
  logic             cfg_wr;

  arwt_slot_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (rd_req),
    .wr_i      (wr_req),
    .clear_i   (ram_clear),
    .rd_data_o (rd_data)
  );

  arwt_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .data_i     (res),
    .can_push_o (can_push),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .data_o     (out_res)
  );

  assign m_axis_tdata  = {1'b0, out_res.brk, out_res.status, out_res.hit, out_res.slot_index};
  assign m_axis_tlast  = out_res.last;
  assign s_axis_tready = (state_q == ST_IDLE);

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite
                  && (paddr[CFG_ADDR_W-1:2] == REG_BRK_ADDR);
  assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_BRK_ADDR) ? brk_addr_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brk_addr_q <= '0;
    end else if (cfg_wr) begin
      brk_addr_q <= pwdata;
    end
  end

  // Per-entry compares
  assign cmp_idx_w  = CNT_W'(cmp_idx_q);
  assign cmp_active = active_q[cmp_idx_q];
  assign check_hit  = cmp_active && (end_q > END_W'(rd_data.low))
                      && (END_W'(base_q) < rd_data.high);
  assign arm_match  = (rd_data.low == base_q) && (rd_data.high == end_q);
  assign arm_free   = (cmp_idx_w >= hw_q) || !cmp_active;
  assign dis_in     = (rd_data.low >= base_q) && (rd_data.low < limit_q);

  // Scan flow: a further hit waits while the output register is busy
  assign stall = cmp_vld_q && (mode_q == MODE_CHECK) && check_hit
                 && pend_vld_q && !can_push;
  always_comb begin
    stop = 1'b0;
    unique case (mode_q)
      MODE_CHECK:  stop = check_hit && (hits_q == HITS_W'(MAX_OUT - 1));
      MODE_ARM:    stop = arm_match || arm_free;
      MODE_DISARM: stop = 1'b0;
      MODE_CLEAR:  stop = 1'b0;
      default:     stop = 1'b0;
    endcase
  end
  assign proc      = cmp_vld_q && !stall;
  assign done_scan = proc && (stop || cmp_last_q);
  assign issue     = (state_q == ST_SCAN) && (rem_q != '0) && !stall && !done_scan;

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    base_d     = base_q;
    end_d      = end_q;
    limit_d    = limit_q;
    remove_d   = remove_q;
    brk_d      = brk_q;
    hw_d       = hw_q;
    active_d   = active_q;
    ptr_d      = ptr_q;
    rem_d      = rem_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    cmp_last_d = cmp_last_q;
    pend_vld_d = pend_vld_q;
    pend_idx_d = pend_idx_q;
    hits_d     = hits_q;
    full_d     = full_q;
    top_d      = top_q;
    rd_req     = '0;
    wr_req     = '0;
    ram_clear  = 1'b0;
    push       = 1'b0;
    res        = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          // Latch the item and set up the scan
          mode_d     = mode_e'(s_axis_tuser[1:0]);
          base_d     = s_axis_tdata[31:0];
          end_d      = END_W'(s_axis_tdata[31:0]) + END_W'(s_axis_tdata[47:32]);
          limit_d    = s_axis_tdata[79:48];
          remove_d   = s_axis_tdata[80];
          pend_vld_d = 1'b0;
          hits_d     = '0;
          full_d     = 1'b0;
          top_d      = '0;
          unique case (mode_e'(s_axis_tuser[1:0]))
            MODE_CHECK: begin
              rem_d   = hw_q;
              ptr_d   = IDX_W'(hw_q - CNT_W'(1));
              state_d = (hw_q != '0) ? ST_SCAN : ST_DRAIN;
            end
            MODE_ARM: begin
              if (s_axis_tdata[31:0] == brk_addr_q) begin
                brk_d = 1'b1;
              end
              rem_d   = CNT_W'(SLOTS);
              ptr_d   = '0;
              state_d = ST_SCAN;
            end
            MODE_DISARM: begin
              rem_d   = hw_q;
              ptr_d   = '0;
              state_d = (hw_q != '0) ? ST_SCAN : ST_DRAIN;
            end
            MODE_CLEAR: begin
              active_d  = '0;
              hw_d      = '0;
              brk_d     = 1'b0;
              ram_clear = 1'b1;
              state_d   = ST_DRAIN;
            end
            default: state_d = ST_DRAIN;
          endcase
        end
      end

      ST_SCAN: begin
        // Issue the next slot read, or repeat the held one on a stall
        if (stall) begin
          rd_req.en   = 1'b1;
          rd_req.addr = cmp_idx_q;
          cmp_vld_d   = 1'b1;
        end else if (issue) begin
          rd_req.en   = 1'b1;
          rd_req.addr = ptr_q;
          cmp_vld_d   = 1'b1;
          cmp_idx_d   = ptr_q;
          cmp_last_d  = (rem_q == CNT_W'(1));
          rem_d       = rem_q - CNT_W'(1);
          ptr_d       = (mode_q == MODE_CHECK) ? ptr_q - IDX_W'(1) : ptr_q + IDX_W'(1);
        end

        // Act on the entry read last cycle
        if (proc) begin
          unique case (mode_q)
            MODE_CHECK: begin
              if (check_hit) begin
                if (pend_vld_q) begin
                  push           = 1'b1;
                  res.slot_index = IDX_OUT_W'(pend_idx_q);
                  res.hit        = 1'b1;
                  res.brk        = brk_q;
                end
                pend_vld_d = 1'b1;
                pend_idx_d = cmp_idx_q;
                hits_d     = hits_q + HITS_W'(1);
              end
            end
            MODE_ARM: begin
              if (stop) begin
                if (arm_match && remove_q) begin
                  active_d[cmp_idx_q] = 1'b0;
                end else begin
                  wr_req.en           = 1'b1;
                  wr_req.addr         = cmp_idx_q;
                  wr_req.data.low     = base_q;
                  wr_req.data.high    = end_q;
                  active_d[cmp_idx_q] = 1'b1;
                  if (cmp_idx_w >= hw_q) begin
                    hw_d = cmp_idx_w + CNT_W'(1);
                  end
                end
              end else if (cmp_last_q) begin
                full_d = 1'b1;
              end
            end
            MODE_DISARM: begin
              if (cmp_active) begin
                if (dis_in) begin
                  active_d[cmp_idx_q] = 1'b0;
                end else begin
                  top_d = cmp_idx_w + CNT_W'(1);
                end
              end
              if (cmp_last_q) begin
                hw_d = (cmp_active && !dis_in) ? cmp_idx_w + CNT_W'(1) : top_q;
              end
            end
            MODE_CLEAR: begin
            end
            default: begin
            end
          endcase
          if (done_scan) begin
            cmp_vld_d = 1'b0;
            state_d   = ST_DRAIN;
          end
        end
      end

      ST_DRAIN: begin
        // Emit the final result of the item
        if (can_push) begin
          push           = 1'b1;
          res.slot_index = pend_vld_q ? IDX_OUT_W'(pend_idx_q) : '0;
          res.hit        = pend_vld_q;
          res.last       = 1'b1;
          res.status     = full_q;
          res.brk        = brk_q;
          state_d        = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mode_q     <= MODE_CHECK;
      base_q     <= '0;
      end_q      <= '0;
      limit_q    <= '0;
      remove_q   <= 1'b0;
      brk_q      <= 1'b0;
      hw_q       <= '0;
      active_q   <= '0;
      ptr_q      <= '0;
      rem_q      <= '0;
      cmp_vld_q  <= 1'b0;
      cmp_idx_q  <= '0;
      cmp_last_q <= 1'b0;
      pend_vld_q <= 1'b0;
      pend_idx_q <= '0;
      hits_q     <= '0;
      full_q     <= 1'b0;
      top_q      <= '0;
    end else begin
      state_q    <= state_d;
      mode_q     <= mode_d;
      base_q     <= base_d;
      end_q      <= end_d;
      limit_q    <= limit_d;
      remove_q   <= remove_d;
      brk_q      <= brk_d;
      hw_q       <= hw_d;
      active_q   <= active_d;
      ptr_q      <= ptr_d;
      rem_q      <= rem_d;
      cmp_vld_q  <= cmp_vld_d;
      cmp_idx_q  <= cmp_idx_d;
      cmp_last_q <= cmp_last_d;
      pend_vld_q <= pend_vld_d;
      pend_idx_q <= pend_idx_d;
      hits_q     <= hits_d;
      full_q     <= full_d;
      top_q      <= top_d;
    end
  end

endmodule
`default_nettype wire

@@ hdl/arwt_checker.sv @@
`default_nettype none
module arwt_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [arwt_pkg::M_DATA_W-1:0]       m_axis_tdata,
  input logic                               m_axis_tlast
);
  import arwt_pkg::*;

  // One item at a time: no new item right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken in the cycle after an accept");

  // A result without a hit closes its item
  a_nohit_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[4]) |-> m_axis_tlast)
    else $error("no-hit result without last");

  // Table full is reported only on a lone no-hit result
  a_full_nohit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[5]) |-> (!m_axis_tdata[4] && m_axis_tlast))
    else $error("table full with a hit or without last");

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled result changed");

endmodule

bind address_range_watch_table arwt_checker u_arwt_checker (.*);
`default_nettype wire

@@ tb/sv/watch_table_monitor.sv @@
module watch_table_monitor
  import arwt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  // [31:0] base_address, [47:32] length, [79:48] limit_address,
  // [80] remove_request, [87:81] zero
  input  logic [S_DATA_W-1:0]   s_axis_tdata,
  // [1:0] mode
  input  logic [S_USER_W-1:0]   s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [3:0] slot_index, [4] hit, [5] status, [6] break_disabled, [7] zero
  input  logic [M_DATA_W-1:0]   m_axis_tdata,
  input  logic                  m_axis_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int                    fail_count_o,
  output int                    pending_o
);

  // Shadow copy of the watch table
  logic [ADDR_W-1:0] range_low   [SLOTS];
  logic [END_W-1:0]  range_end   [SLOTS];
  logic              range_armed [SLOTS];
  int                mark;
  logic              brk_flag;
  logic [ADDR_W-1:0] brk_addr;

  // Results still owed by the block, oldest first
  res_t expected_results [$];

  function automatic res_t make_result(input int idx, input logic hit, input logic last,
                                       input logic status);
    res_t r;
    r.slot_index = idx[IDX_OUT_W-1:0];
    r.hit        = hit;
    r.last       = last;
    r.status     = status;
    r.brk        = brk_flag;
    return r;
  endfunction

  task automatic clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      range_low[i]   = '0;
      range_end[i]   = '0;
      range_armed[i] = 1'b0;
    end
    mark     = 0;
    brk_flag = 1'b0;
  endtask

  // Walk from the top slot down, collecting every overlapping armed range
  task automatic predict_check(input logic [ADDR_W-1:0] base, input logic [LEN_W-1:0] len);
    logic [END_W-1:0] stop;
    int               found [$];
    int               top;
    stop = {1'b0, base} + END_W'(len);
    top  = (mark < SLOTS) ? mark : SLOTS;
    for (int i = top - 1; i >= 0 && found.size() < MAX_OUT; i--) begin
      if (range_armed[i] && stop > {1'b0, range_low[i]} && {1'b0, base} < range_end[i])
        found.push_back(i);
    end
    if (found.size() == 0) begin
      expected_results.push_back(make_result(0, 1'b0, 1'b1, 1'b0));
    end else begin
      foreach (found[k])
        expected_results.push_back(make_result(found[k], 1'b1, k == found.size() - 1, 1'b0));
    end
  endtask

  // Free an equal range, then take the first free slot; return 1 when the table is full
  function automatic logic predict_arm(input logic [ADDR_W-1:0] base,
                                       input logic [LEN_W-1:0] len, input logic rm);
    logic [END_W-1:0] stop;
    stop = {1'b0, base} + END_W'(len);
    if (base == brk_addr)
      brk_flag = 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      if (range_low[i] == base && range_end[i] == stop) begin
        range_armed[i] = 1'b0;
        if (rm)
          return 1'b0;
      end
      if (i >= mark || !range_armed[i]) begin
        range_armed[i] = 1'b1;
        range_low[i]   = base;
        range_end[i]   = stop;
        if (i >= mark)
          mark = i + 1;
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Drop armed slots whose base falls in [lo, hi) and pull the mark down
  task automatic predict_disarm(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
    int top;
    top = 0;
    for (int i = 0; i < mark && i < SLOTS; i++) begin
      if (range_armed[i]) begin
        if (range_low[i] >= lo && range_low[i] < hi)
          range_armed[i] = 1'b0;
        else
          top = i + 1;
      end
    end
    mark = top;
  endtask

  // Track register writes and input items, and score every output item
  always @(posedge clk_i or negedge rst_ni) begin
    res_t  got;
    res_t  want;
    logic  full;
    mode_e op;
    if (!rst_ni) begin
      clear_table();
      brk_addr = '0;
      expected_results.delete();
      fail_count_o = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[CFG_ADDR_W-1:2] == REG_BRK_ADDR)
        brk_addr = pwdata;

      if (s_axis_tvalid && s_axis_tready) begin
        op = mode_e'(s_axis_tuser[1:0]);
        case (op)
          MODE_CHECK: begin
            predict_check(s_axis_tdata[31:0], s_axis_tdata[47:32]);
          end
          MODE_ARM: begin
            full = predict_arm(s_axis_tdata[31:0], s_axis_tdata[47:32], s_axis_tdata[80]);
            expected_results.push_back(make_result(0, 1'b0, 1'b1, full));
          end
          MODE_DISARM: begin
            predict_disarm(s_axis_tdata[31:0], s_axis_tdata[79:48]);
            expected_results.push_back(make_result(0, 1'b0, 1'b1, 1'b0));
          end
          MODE_CLEAR: begin
            clear_table();
            expected_results.push_back(make_result(0, 1'b0, 1'b1, 1'b0));
          end
        endcase
      end

      if (m_axis_tvalid && m_axis_tready) begin
        got.slot_index = m_axis_tdata[3:0];
        got.hit        = m_axis_tdata[4];
        got.status     = m_axis_tdata[5];
        got.brk        = m_axis_tdata[6];
        got.last       = m_axis_tlast;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: slot %0d hit %b last %b status %b brk %b",
                   $time, got.slot_index, got.hit, got.last, got.status, got.brk);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (got.slot_index != want.slot_index || got.hit != want.hit ||
              got.last != want.last || got.status != want.status || got.brk != want.brk) begin
            $display("%0t: result mismatch: expected slot %0d hit %b last %b status %b brk %b",
                     $time, want.slot_index, want.hit, want.last, want.status, want.brk);
            $display("%0t:                  actual   slot %0d hit %b last %b status %b brk %b",
                     $time, got.slot_index, got.hit, got.last, got.status, got.brk);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = expected_results.size();
  end

endmodule

@@ tb/sv/tb.sv @@
module tb;
  import arwt_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [ADDR_W-1:0] REGIONS [6] = '{
    32'h0000_0000, 32'h0000_1000, 32'h0001_0000,
    32'h8000_0000, 32'hFFFF_0000, 32'hFFFF_FFC0
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata;
  logic [S_USER_W-1:0]   s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_DATA_W-1:0]   m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int   fail_count;
  int   pending;
  bit   calm = 1'b0;
  int   hold_asked = 0;
  int   hold_done = 0;
  int   cycles = 0;

  // Recently armed ranges, reused so that arms and removes hit equal ranges
  logic [ADDR_W-1:0] armed_base [$];
  logic [LEN_W-1:0]  armed_len  [$];

  address_range_watch_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  watch_table_monitor u_monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one; none while calm
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm)
      return 0;
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Drive the result ready, with random stalls and one long hold-off on request
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_asked != hold_done) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_done++;
      end else begin
        stall = pick_gap();
        if (stall == 0) begin
          m_axis_tready = 1'b1;
        end else begin
          m_axis_tready = 1'b0;
          repeat (stall - 1) @(negedge clk_i);
        end
      end
    end
  end

  // End the run if it hangs
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  task automatic reg_write(input logic [CFG_ADDR_W-3:0] idx, input logic [CFG_DATA_W-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Offer one item and hold it until taken; called at a falling edge
  task automatic send_item(input mode_e op, input logic [ADDR_W-1:0] base,
                           input logic [LEN_W-1:0] len, input logic [ADDR_W-1:0] lim,
                           input logic rm);
    int gap;
    s_axis_tuser  = op;
    s_axis_tdata  = {{(S_DATA_W - 81){1'b0}}, rm, lim, len, base};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Stop offering, wait for every owed result, then let the block go quiet
  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Random operation, biased toward a few address regions so ranges overlap
  task automatic random_item();
    int                r;
    int                k;
    bit                reuse;
    mode_e             op;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] lim;
    logic [LEN_W-1:0]  len;
    logic              rm;
    r = $urandom_range(0, 99);
    op = (r < 45) ? MODE_CHECK : (r < 80) ? MODE_ARM : (r < 96) ? MODE_DISARM : MODE_CLEAR;

    r = $urandom_range(0, 9);
    if (r == 0)
      len = '0;
    else if (r == 1)
      len = '1;
    else if (r < 4)
      len = LEN_W'($urandom);
    else
      len = LEN_W'($urandom_range(1, 48));

    reuse = armed_base.size() > 0 && $urandom_range(0, 3) == 0;
    if (reuse) begin
      k    = $urandom_range(0, armed_base.size() - 1);
      base = armed_base[k];
      if (op == MODE_ARM)
        len = armed_len[k];
      else if (op == MODE_CHECK)
        base = base + ADDR_W'($urandom_range(0, 15));
    end else if ($urandom_range(0, 4) == 0) begin
      base = $urandom;
    end else begin
      base = REGIONS[$urandom_range(0, 5)] + ADDR_W'($urandom_range(0, 63));
    end

    rm = (op == MODE_ARM) ? ($urandom_range(0, 3) == 0) : 1'($urandom);
    if (op == MODE_DISARM && $urandom_range(0, 4) != 0)
      lim = base + ADDR_W'($urandom_range(0, 96));
    else
      lim = $urandom;

    if (op == MODE_ARM && !rm) begin
      armed_base.push_back(base);
      armed_len.push_back(len);
      if (armed_base.size() > 8) begin
        void'(armed_base.pop_front());
        void'(armed_len.pop_front());
      end
    end
    send_item(op, base, len, lim, rm);
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    rst_ni        = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty table, zero length, remove, full table, top of the address space
    reg_write(REG_BRK_ADDR, '0);
    send_item(MODE_CHECK, '0, '0, '0, 1'b0);
    // base equals the break address, so the flag goes up
    send_item(MODE_ARM, '0, '0, '1, 1'b0);
    send_item(MODE_CHECK, '0, '0, '0, 1'b1);
    send_item(MODE_ARM, '0, '0, '0, 1'b1);
    for (int i = 0; i < SLOTS; i++)
      send_item(MODE_ARM, 32'h1000 + 32'(i) * 32'd16, '1, '0, 1'b0);
    // no slot left; also a remove that finds no equal range
    send_item(MODE_ARM, '1, '1, '0, 1'b1);
    send_item(MODE_CHECK, 32'h1000, '1, '0, 1'b0);
    send_item(MODE_DISARM, 32'h1000, '0, 32'h1080, 1'b0);
    send_item(MODE_ARM, '1, '1, '0, 1'b1);
    // equal range again: replace in place
    send_item(MODE_ARM, '1, '1, '0, 1'b0);
    send_item(MODE_CHECK, '1, 16'd1, '0, 1'b0);
    // reversed disarm range frees nothing
    send_item(MODE_DISARM, 32'h2000, '0, 32'h1000, 1'b0);
    send_item(MODE_DISARM, '0, '0, '1, 1'b0);
    send_item(MODE_CLEAR, '1, '1, '1, 1'b1);

    settle();
    reg_write(REG_BRK_ADDR, '1);
    repeat (60) random_item();

    // Hold the receiver off while items keep coming
    settle();
    reg_write(REG_BRK_ADDR, 32'h0000_1000);
    hold_asked++;
    repeat (50) random_item();

    settle();
    calm = 1'b1;
    reg_write(REG_BRK_ADDR, 32'hFFFF_FFC0);
    repeat (40) random_item();
    settle();
    calm = 1'b0;

    reg_write(REG_BRK_ADDR, $urandom);
    repeat (50) random_item();
    settle();

    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
